// ----- design/bb3_pkg.sv -----
// shared constants and types of the 3x3 box blur stream
`timescale 1ns / 1ps

package bb3_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_CHANNELS = 4;

    // fixed field widths
    localparam int PORT_CHANNELS = 4;
    localparam int BYTE_W        = 8;
    localparam int IMG_WIDTH_W   = 13;
    localparam int IMG_HEIGHT_W  = 16;
    localparam int CH_COUNT_W    = 3;
    localparam int IN_ROW_W      = IMG_HEIGHT_W + 1;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [IMG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [IMG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [CH_COUNT_W-1:0]   RST_CHANNEL_COUNT = 3'd3;

    // 3x3 window geometry
    localparam int WIN_SIDE   = 3;
    localparam int WIN_TAPS   = WIN_SIDE * WIN_SIDE;
    localparam int WIN_CENTER = WIN_SIDE + 1;

    // output queue
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);

    typedef logic [PORT_CHANNELS-1:0][BYTE_W-1:0] bytes_t;

    // control that travels with one word down the pipeline
    typedef struct packed {
        logic                     item;
        logic                     wr;
        logic                     emit;
        logic                     interior;
        logic                     last;
        logic [PORT_CHANNELS-1:0] ch_en;
    } stage_ctrl_t;

    // one result word as held in the output queue
    typedef struct packed {
        logic   result_valid;
        bytes_t ch;
        logic   frame_end;
    } result_word_t;

endpackage

// ----- design/bb3_if.sv -----
// stream interfaces for pixel words in and result words out
`timescale 1ns / 1ps

interface bb3_in_if
    import bb3_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              pad_only;
    logic [BYTE_W-1:0] in_ch0;
    logic [BYTE_W-1:0] in_ch1;
    logic [BYTE_W-1:0] in_ch2;
    logic [BYTE_W-1:0] in_ch3;

    modport source (
        output valid, pad_only, in_ch0, in_ch1, in_ch2, in_ch3,
        input  ready
    );

    modport sink (
        input  valid, pad_only, in_ch0, in_ch1, in_ch2, in_ch3,
        output ready
    );
endinterface

interface bb3_out_if
    import bb3_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              result_valid;
    logic [BYTE_W-1:0] out_ch0;
    logic [BYTE_W-1:0] out_ch1;
    logic [BYTE_W-1:0] out_ch2;
    logic [BYTE_W-1:0] out_ch3;
    logic              frame_end;

    modport source (
        output valid, result_valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_end,
        input  ready
    );

    modport sink (
        input  valid, result_valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_end,
        output ready
    );
endinterface

// ----- design/bb3_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bb3_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/bb3_ctrl.sv -----
// position counters, frame bookkeeping and first pipeline register
`timescale 1ns / 1ps

module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [IMG_WIDTH_W-1:0]            image_width,
    input  logic [IMG_HEIGHT_W-1:0]           image_height,
    input  logic [CH_COUNT_W-1:0]             channel_count,
    input  logic                              take,
    input  logic                              pad_only,
    input  bytes_t                            in_bytes,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
    output stage_ctrl_t                       s1_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
    output logic [BYTE_W*MAX_CHANNELS-1:0]    s1_pix
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int PIX_W = BYTE_W * MAX_CHANNELS;

    logic [COL_W-1:0]        in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0]     in_row_reg, in_row_next;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [IMG_HEIGHT_W-1:0] out_row_reg, out_row_next;

    stage_ctrl_t             s1_ctrl_reg, s1_ctrl_next;
    logic [COL_W-1:0]        s1_col_reg;
    logic [PIX_W-1:0]        s1_pix_reg, s1_pix_next;

    logic [W_W-1:0]          width_eff;
    logic [IMG_HEIGHT_W-1:0] height_eff;
    logic [COL_W:0]          in_col_inc;
    logic [COL_W:0]          out_col_inc;
    logic [IN_ROW_W-1:0]     out_row_inc;
    logic                    in_frame;
    logic                    do_step;
    logic                    due;
    logic                    abandon;
    logic                    emit;
    logic                    last;
    logic                    interior;

    // effective sizes from the registers
    always_comb
    begin
        if (image_width == '0)
        begin
            width_eff = W_W'(1);
        end
        else if (int'(image_width) > MAX_WIDTH)
        begin
            width_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = W_W'(image_width);
        end
        height_eff = (image_height == '0) ? IMG_HEIGHT_W'(1) : image_height;
    end

    // position decode for the word at the input
    always_comb
    begin
        in_col_inc  = {1'b0, in_col_reg} + 1'b1;
        out_col_inc = {1'b0, out_col_reg} + 1'b1;
        out_row_inc = {1'b0, out_row_reg} + 1'b1;
        in_frame    = in_row_reg < {1'b0, height_eff};
        do_step     = take && !(pad_only && in_frame);
        due         = (in_row_reg > IN_ROW_W'(1)) ||
                      ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));
        abandon     = due && (out_row_reg >= height_eff);
        emit        = due && !abandon;
        last        = (out_row_inc >= {1'b0, height_eff}) && (out_col_inc >= width_eff);
        interior    = (out_row_reg != '0) && (out_row_inc < {1'b0, height_eff}) &&
                      (out_col_reg != '0) && (out_col_inc < width_eff);
    end

    // counter advance, frame end and abandon clear everything
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (do_step)
        begin
            if (in_col_inc >= width_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = COL_W'(in_col_inc);
            end

            if (abandon || (emit && last))
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (emit)
            begin
                if (out_col_inc >= width_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = COL_W'(out_col_inc);
                end
            end
        end
    end

    // control and pixel word for the line store stage
    always_comb
    begin
        int nch;
        nch = (int'(channel_count) > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count);
        s1_ctrl_next.item     = take;
        s1_ctrl_next.wr       = do_step;
        s1_ctrl_next.emit     = do_step && emit;
        s1_ctrl_next.interior = interior;
        s1_ctrl_next.last     = last;
        for (int c = 0; c < PORT_CHANNELS; c++)
        begin
            s1_ctrl_next.ch_en[c] = (c < nch);
        end
        // pixels arriving during the flush are dropped
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            s1_pix_next[c*BYTE_W +: BYTE_W] = in_frame ? in_bytes[c] : '0;
        end
    end

    // position counters and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_col_reg <= in_col_reg;
        s1_pix_reg <= s1_pix_next;
    end

    assign rd_addr = in_col_reg;
    assign s1_ctrl = s1_ctrl_reg;
    assign s1_col  = s1_col_reg;
    assign s1_pix  = s1_pix_reg;
endmodule

// ----- design/bb3_window.sv -----
// line store read-modify-write with forwarding and the 3x3 window registers
`timescale 1ns / 1ps

module bb3_window
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
    input  stage_ctrl_t                    s1_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]   s1_col,
    input  logic [BYTE_W*MAX_CHANNELS-1:0] s1_pix,
    output stage_ctrl_t                    s2_ctrl,
    output logic [BYTE_W*MAX_CHANNELS-1:0] win [WIN_TAPS]
);
    localparam int PIX_W   = BYTE_W * MAX_CHANNELS;
    localparam int ENTRY_W = 2 * PIX_W;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] fwd_entry_reg;
    logic               fwd_hit_reg, fwd_hit_next;
    logic [PIX_W-1:0]   upper_pix;
    logic [PIX_W-1:0]   lower_pix;
    logic [PIX_W-1:0]   win_reg  [WIN_TAPS];
    logic [PIX_W-1:0]   win_next [WIN_TAPS];
    stage_ctrl_t        s2_ctrl_reg;

    // one entry holds the two rows above the input row, upper half oldest
    bb3_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_ctrl.wr),
        .waddr (s1_col),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // forward the entry being written when the next word reads the same column
    always_comb
    begin
        rd_entry     = fwd_hit_reg ? fwd_entry_reg : ram_rdata;
        upper_pix    = rd_entry[PIX_W +: PIX_W];
        lower_pix    = rd_entry[0 +: PIX_W];
        wr_entry     = {lower_pix, s1_pix};
        fwd_hit_next = s1_ctrl.wr && (rd_addr == s1_col);
    end

    // window shifts left one column, new column from the line store and input
    always_comb
    begin
        win_next = win_reg;
        if (s1_ctrl.wr)
        begin
            for (int r = 0; r < WIN_SIDE; r++)
            begin
                for (int c = 0; c < WIN_SIDE - 1; c++)
                begin
                    win_next[r*WIN_SIDE + c] = win_reg[r*WIN_SIDE + c + 1];
                end
            end
            win_next[WIN_SIDE-1]     = upper_pix;
            win_next[2*WIN_SIDE-1]   = lower_pix;
            win_next[WIN_TAPS-1]     = s1_pix;
        end
    end

    // window, forward flag and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
            fwd_hit_reg <= 1'b0;
            s2_ctrl_reg <= '0;
        end
        else
        begin
            win_reg     <= win_next;
            fwd_hit_reg <= fwd_hit_next;
            s2_ctrl_reg <= s1_ctrl;
        end
    end

    // forwarded entry
    always_ff @(posedge clk)
    begin
        fwd_entry_reg <= wr_entry;
    end

    assign s2_ctrl = s2_ctrl_reg;
    assign win     = win_reg;
endmodule

// ----- design/bb3_filter.sv -----
// neighbourhood sums, divide by nine and result word assembly
`timescale 1ns / 1ps

module bb3_filter
    import bb3_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stage_ctrl_t                    s2_ctrl,
    input  logic [BYTE_W*MAX_CHANNELS-1:0] win [WIN_TAPS],
    output logic                           push,
    output result_word_t                   push_word
);
    // floor(x / 9) as (x * recip) >> shift, exact for sums below 2^15
    localparam int SUM_W      = 12;
    localparam int DIV_SHIFT  = 16;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((1 << DIV_SHIFT) / WIN_TAPS + 1);

    logic [SUM_W-1:0]  sum_reg    [MAX_CHANNELS];
    logic [SUM_W-1:0]  sum_next   [MAX_CHANNELS];
    logic [BYTE_W-1:0] center_reg [MAX_CHANNELS];
    logic [BYTE_W-1:0] center_next[MAX_CHANNELS];
    stage_ctrl_t       s3_ctrl_reg;

    function automatic logic [BYTE_W-1:0] div_by_taps(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(DIV_RECIP);
        return prod[DIV_SHIFT +: BYTE_W];
    endfunction

    // per channel sum of the nine window bytes, row by row
    always_comb
    begin
        logic [SUM_W-1:0] row_sum [WIN_SIDE];
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            for (int r = 0; r < WIN_SIDE; r++)
            begin
                row_sum[r] = SUM_W'(win[r*WIN_SIDE][c*BYTE_W +: BYTE_W]) +
                             SUM_W'(win[r*WIN_SIDE + 1][c*BYTE_W +: BYTE_W]) +
                             SUM_W'(win[r*WIN_SIDE + 2][c*BYTE_W +: BYTE_W]);
            end
            sum_next[c]    = row_sum[0] + row_sum[1] + row_sum[2];
            center_next[c] = win[WIN_CENTER][c*BYTE_W +: BYTE_W];
        end
    end

    // sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s3_ctrl_reg <= s2_ctrl;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        center_reg <= center_next;
    end

    // blurred for interior, centre for border, zero past the channel count and in words without a pixel
    always_comb
    begin
        push                   = s3_ctrl_reg.item;
        push_word.result_valid = s3_ctrl_reg.emit;
        push_word.frame_end    = s3_ctrl_reg.emit && s3_ctrl_reg.last;
        push_word.ch           = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (s3_ctrl_reg.emit && s3_ctrl_reg.ch_en[c])
            begin
                push_word.ch[c] = s3_ctrl_reg.interior ? div_by_taps(sum_reg[c])
                                                       : center_reg[c];
            end
        end
    end
endmodule

// ----- design/bb3_out_fifo.sv -----
// output queue with credit count that sets input ready
`timescale 1ns / 1ps

module bb3_out_fifo
    import bb3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic         push,
    input  result_word_t push_word,
    output logic         space,
    bb3_out_if.source    result
);
    result_word_t        mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg, count_next;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic                space_reg;
    logic                pop;
    result_word_t        head;

    // credits cover words in the pipeline plus words in the queue
    always_comb
    begin
        pop         = result.valid && result.ready;
        count_next  = count_reg + CREDIT_W'(push) - CREDIT_W'(pop);
        credit_next = credit_reg + CREDIT_W'(take) - CREDIT_W'(pop);
        head        = mem_reg[rd_ptr_reg];
    end

    // pointers, fill and credit counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
            space_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg  <= count_next;
            credit_reg <= credit_next;
            space_reg  <= credit_next < CREDIT_W'(OUT_DEPTH);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign space               = space_reg;
    assign result.valid        = (count_reg != '0);
    assign result.result_valid = head.result_valid;
    assign result.out_ch0      = head.ch[0];
    assign result.out_ch1      = head.ch[1];
    assign result.out_ch2      = head.ch[2];
    assign result.out_ch3      = head.ch[3];
    assign result.frame_end    = head.frame_end;
endmodule

// ----- design/box_blur_3x3_stream_top.sv -----
// top level of the 3x3 box blur pixel stream
`timescale 1ns / 1ps

// 3x3 box blur over a raster-order pixel stream. One word is taken per clock
// while ready is high, and every taken word gives exactly one result word; a
// result carries a pixel (result_valid high) once the stream is width+1 words
// ahead of it, and pad words after the frame flush the last width+1 results.
// Throughput is one word per cycle, set by the line store: a single ram of
// MAX_WIDTH entries holding the two previous rows, read at input and written
// back in the next cycle, with a forward path for one-pixel-wide frames. A
// taken word passes the line store read, window and neighbourhood sum
// registers to the output queue; the queue holds eight words and ready drops
// once the pipeline and the queue together hold eight words, and at reset. The
// line store needs no clearing pass: stale entries never reach a result.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
module box_blur_3x3_stream_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bb3_in_if.sink                 pixel,
    bb3_out_if.source              blurred
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PIX_W = BYTE_W * MAX_CHANNELS;

    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [IMG_HEIGHT_W-1:0] image_height_reg;
    logic [CH_COUNT_W-1:0]   channel_count_reg;

    logic                    take;
    logic                    space;
    bytes_t                  in_bytes;
    logic [COL_W-1:0]        rd_addr;
    stage_ctrl_t             s1_ctrl;
    logic [COL_W-1:0]        s1_col;
    logic [PIX_W-1:0]        s1_pix;
    stage_ctrl_t             s2_ctrl;
    logic [PIX_W-1:0]        win [WIN_TAPS];
    logic                    push;
    result_word_t            push_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            channel_count_reg <= RST_CHANNEL_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IMG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[IMG_HEIGHT_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CH_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // input handshake
    assign take        = pixel.valid && pixel.ready;
    assign pixel.ready = space;
    assign in_bytes    = {pixel.in_ch3, pixel.in_ch2, pixel.in_ch1, pixel.in_ch0};

    bb3_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .channel_count (channel_count_reg),
        .take          (take),
        .pad_only      (pixel.pad_only),
        .in_bytes      (in_bytes),
        .rd_addr       (rd_addr),
        .s1_ctrl       (s1_ctrl),
        .s1_col        (s1_col),
        .s1_pix        (s1_pix)
    );

    bb3_window #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .s1_ctrl (s1_ctrl),
        .s1_col  (s1_col),
        .s1_pix  (s1_pix),
        .s2_ctrl (s2_ctrl),
        .win     (win)
    );

    bb3_filter #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_ctrl   (s2_ctrl),
        .win       (win),
        .push      (push),
        .push_word (push_word)
    );

    bb3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .push_word (push_word),
        .space     (space),
        .result    (blurred)
    );

    // every taken word reaches the output queue
    a_take_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##3 push)
        else $error("taken word did not reach the output queue");

    // nothing enters the queue that was not taken
    a_push_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(take, 3))
        else $error("result word without a taken word");

    // a word without a pixel carries only zeros
    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (blurred.valid && !blurred.result_valid) |->
        (blurred.out_ch0 == '0 && blurred.out_ch1 == '0 && blurred.out_ch2 == '0 &&
         blurred.out_ch3 == '0 && !blurred.frame_end))
        else $error("empty result word has non-zero fields");
endmodule

// ----- verif/tb_box_blur_3x3_stream_top.sv -----
// testbench for the 3x3 box blur stream: directed and random frames checked word by word
`timescale 1ns / 1ps

module tb_box_blur_3x3_stream_top
    import bb3_pkg::*;
();

    localparam int LINE_LEN     = DEF_MAX_WIDTH;
    localparam int HOLD_OFF_LEN = 300;
    localparam int RANDOM_ITEMS = 1500;

    // one word offered on the pixel channel
    typedef struct packed {
        logic   pad;
        bytes_t px;
    } pixel_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bb3_in_if  pixel_if ();
    bb3_out_if blurred_if ();

    box_blur_3x3_stream_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_if),
        .blurred   (blurred_if)
    );

    // words waiting to be offered, and blurred words still owed by the block
    pixel_word_t  pixel_backlog[$];
    result_word_t blurred_due[$];

    int unsigned errors;
    int unsigned words_out;
    int unsigned items_queued;
    int unsigned cycle_no;
    logic        quiet_stretch;
    bit          hold_off_go;
    int unsigned hold_cycles;
    logic        holding;

    // shadow of the configuration registers
    logic [IMG_WIDTH_W-1:0]  cfg_width  = RST_IMAGE_WIDTH;
    logic [IMG_HEIGHT_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
    logic [CH_COUNT_W-1:0]   cfg_chans  = RST_CHANNEL_COUNT;

    // shadow of the line stores, window and position counters
    bytes_t      row_above2[LINE_LEN];
    bytes_t      row_above1[LINE_LEN];
    bytes_t      win[WIN_TAPS];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    assign quiet_stretch = (cycle_no % 3000) < 800;
    assign holding       = hold_off_go && (hold_cycles < HOLD_OFF_LEN);

    // long receiver hold-off, counted here once triggered
    always @(posedge clk)
        if (holding)
            hold_cycles <= hold_cycles + 1;

    function automatic int unsigned eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > LINE_LEN)
            return LINE_LEN;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic void clear_positions();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // advance the shadow by one taken word and give the word the block owes for it
    function automatic result_word_t blur_next(pixel_word_t w);
        int unsigned  wd;
        int unsigned  ht;
        int unsigned  nch;
        int unsigned  col;
        int unsigned  sum;
        bytes_t       pix;
        bytes_t       up;
        bytes_t       lo;
        bit           in_frame;
        bit           due;
        bit           interior;
        bit           last;
        result_word_t r;
        wd       = eff_width();
        ht       = eff_height();
        nch      = (cfg_chans > PORT_CHANNELS) ? PORT_CHANNELS : cfg_chans;
        r        = '0;
        in_frame = in_row < ht;

        // pad while rows remain: ignored
        if (w.pad && in_frame)
            return r;

        // once all rows are in, pixel data is dropped
        pix = in_frame ? w.px : '0;

        // shift the window and rotate the line stores
        col = (in_col < LINE_LEN) ? in_col : 0;
        up  = row_above2[col];
        lo  = row_above1[col];
        for (int k = 0; k < WIN_SIDE; k++)
        begin
            win[k * WIN_SIDE]     = win[k * WIN_SIDE + 1];
            win[k * WIN_SIDE + 1] = win[k * WIN_SIDE + 2];
        end
        win[2]          = up;
        win[5]          = lo;
        win[8]          = pix;
        row_above2[col] = lo;
        row_above1[col] = pix;

        due = (in_row > 1) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= wd)
        begin
            in_col = 0;
            in_row++;
        end
        else
            in_col++;

        if (!due)
            return r;

        // output row beyond the height: frame abandoned
        if (out_row >= ht)
        begin
            clear_positions();
            return r;
        end

        interior = out_row >= 1 && out_row + 1 < ht && out_col >= 1 && out_col + 1 < wd;
        last     = out_row + 1 >= ht && out_col + 1 >= wd;

        r.result_valid = 1'b1;
        for (int c = 0; c < PORT_CHANNELS; c++)
        begin
            if (c < nch)
            begin
                if (interior)
                begin
                    sum = 0;
                    for (int k = 0; k < WIN_TAPS; k++)
                        sum += win[k][c];
                    r.ch[c] = 8'(sum / 9);
                end
                else
                    r.ch[c] = win[WIN_CENTER][c];
            end
        end
        r.frame_end = last;

        if (last)
            clear_positions();
        else if (out_col + 1 >= wd)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 100)
            $display("%0t ns: mismatch on result word %0d: %s", $time, words_out, what);
        errors++;
    endtask

    // pixel driver
    always @(posedge clk)
    begin : feed_pixels
        pixel_word_t nxt;
        if (!rst_n)
            pixel_if.valid <= 1'b0;
        else if (!pixel_if.valid || pixel_if.ready)
        begin
            if (pixel_backlog.size() != 0 && (quiet_stretch || $urandom_range(99) >= 16))
            begin
                nxt = pixel_backlog.pop_front();
                pixel_if.valid    <= 1'b1;
                pixel_if.pad_only <= nxt.pad;
                pixel_if.in_ch0   <= nxt.px[0];
                pixel_if.in_ch1   <= nxt.px[1];
                pixel_if.in_ch2   <= nxt.px[2];
                pixel_if.in_ch3   <= nxt.px[3];
            end
            else
                pixel_if.valid <= 1'b0;
        end
    end

    // result receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            blurred_if.ready <= 1'b0;
        else
            blurred_if.ready <= !holding && (quiet_stretch || $urandom_range(99) >= 16);
    end

    // predict on every taken pixel word, check every taken result word
    always @(posedge clk)
    begin : watch_words
        pixel_word_t  taken;
        result_word_t got;
        result_word_t want;
        if (rst_n)
        begin
            if (pixel_if.valid && pixel_if.ready)
            begin
                taken.pad   = pixel_if.pad_only;
                taken.px[0] = pixel_if.in_ch0;
                taken.px[1] = pixel_if.in_ch1;
                taken.px[2] = pixel_if.in_ch2;
                taken.px[3] = pixel_if.in_ch3;
                blurred_due.push_back(blur_next(taken));
            end
            if (blurred_if.valid && blurred_if.ready)
            begin
                got.result_valid = blurred_if.result_valid;
                got.ch[0]        = blurred_if.out_ch0;
                got.ch[1]        = blurred_if.out_ch1;
                got.ch[2]        = blurred_if.out_ch2;
                got.ch[3]        = blurred_if.out_ch3;
                got.frame_end    = blurred_if.frame_end;
                if (blurred_due.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = blurred_due.pop_front();
                    if (got.result_valid !== want.result_valid)
                        report_mismatch($sformatf("result_valid got %b expected %b",
                                                  got.result_valid, want.result_valid));
                    for (int c = 0; c < PORT_CHANNELS; c++)
                        if (got.ch[c] !== want.ch[c])
                            report_mismatch($sformatf("out_ch%0d got %0d expected %0d",
                                                      c, got.ch[c], want.ch[c]));
                    if (got.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %b expected %b",
                                                  got.frame_end, want.frame_end));
                end
                words_out++;
            end
        end
    end

    // register write: enable raised with index and data, then dropped
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_IMAGE_WIDTH:   cfg_width  = value[IMG_WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT:  cfg_height = value[IMG_HEIGHT_W-1:0];
            CFG_CHANNEL_COUNT: cfg_chans  = value[CH_COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned n);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, n);
    endtask

    // wait until every owed word is out, then let the pipeline settle
    task automatic drain_block();
        while (pixel_backlog.size() != 0 || pixel_if.valid || blurred_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic bytes_t rand_pixel();
        bytes_t p;
        for (int c = 0; c < PORT_CHANNELS; c++)
            p[c] = rand_byte();
        return p;
    endfunction

    task automatic push_word(input logic pad, input bytes_t px);
        pixel_word_t w;
        w.pad = pad;
        w.px  = px;
        pixel_backlog.push_back(w);
    endtask

    // one frame at the current sizes, stray pads inside, then the flush
    task automatic push_frame(input int unsigned noise_pct);
        int unsigned wd;
        int unsigned ht;
        wd = eff_width();
        ht = eff_height();
        for (int unsigned k = 0; k < wd * ht; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_word(1'b1, rand_pixel());
            push_word(1'b0, rand_pixel());
            items_queued++;
        end
        // flush, now and then a pixel that the block must treat as a pad
        for (int unsigned k = 0; k <= wd; k++)
        begin
            push_word($urandom_range(99) >= 20, rand_pixel());
            items_queued++;
        end
    endtask

    // fail-safe limit
    initial
    begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        bytes_t      px;
        int unsigned wreg;
        int unsigned hreg;
        int unsigned random_start;
        errors       = 0;
        words_out    = 0;
        items_queued = 0;
        cycle_no     = 0;
        hold_off_go  = 1'b0;
        hold_cycles  = 0;
        for (int k = 0; k < LINE_LEN; k++)
        begin
            row_above2[k] = '0;
            row_above1[k] = '0;
        end
        for (int k = 0; k < WIN_TAPS; k++)
            win[k] = '0;
        clear_positions();

        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = CFG_IMAGE_WIDTH;
        cfg_data            = '0;
        pixel_if.valid      = 1'b0;
        pixel_if.pad_only   = 1'b0;
        pixel_if.in_ch0     = '0;
        pixel_if.in_ch1     = '0;
        pixel_if.in_ch2     = '0;
        pixel_if.in_ch3     = '0;
        blurred_if.ready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 frame, all four channels: full-scale, zero and mixed bytes
        set_geometry(3, 3, 4);
        for (int k = 0; k < 9; k++)
        begin
            px[0] = 8'hFF;
            px[1] = 8'h00;
            px[2] = k[0] ? 8'hFF : 8'h00;
            px[3] = 8'(k * 31);
            push_word(1'b0, px);
            if (k == 4)
                push_word(1'b1, rand_pixel());
        end
        push_word(1'b1, '0);
        push_word(1'b0, rand_pixel());
        push_word(1'b1, '0);
        push_word(1'b1, '0);
        drain_block();

        // zero width and height act as one, zero channels give all zero
        set_geometry(0, 0, 0);
        push_word(1'b0, rand_pixel());
        push_word(1'b1, '0);
        push_word(1'b0, rand_pixel());
        drain_block();

        // tallest frame, then height cut below the output row: frame abandoned
        set_geometry(2, 65535, 7);
        for (int k = 0; k < 6; k++)
            push_word(1'b0, rand_pixel());
        drain_block();
        write_reg(CFG_IMAGE_HEIGHT, 1);
        push_word(1'b0, rand_pixel());
        drain_block();
        push_frame(0);
        drain_block();

        // wider frame with a long receiver hold-off while it streams
        set_geometry(40, 3, 4);
        push_frame(2);
        hold_off_go = 1'b1;
        drain_block();

        // random sizes, one to three frames per setting
        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            wreg = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(1, 12);
            hreg = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(1, 10);
            set_geometry(wreg, hreg, $urandom_range(7));
            repeat ($urandom_range(1, 3))
            begin
                push_frame(5);
                // stray pads between frames are ignored
                if ($urandom_range(9) < 3)
                    repeat ($urandom_range(1, 3))
                        push_word(1'b1, rand_pixel());
            end
            drain_block();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
